### rtl/acm_pkg.sv
// Shared types and constants for the ARP cache engine.
package acm_pkg;

  localparam int IP_W       = 32;
  localparam int MAC_W      = 48;
  localparam int TICK_W     = 48;
  localparam int SLOT_W     = 6;
  localparam int TOTAL_W    = 32;
  localparam int CMD_W      = 2;
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 120;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic [MAC_W-1:0] MAC_BCAST = '1;
  localparam logic [MAC_W-1:0] MAC_ZERO  = '0;
  localparam logic [IP_W-1:0]  IP_ZERO   = '0;

  // register index, taken from paddr[3] (registers sit 8 bytes apart)
  localparam logic REG_TTL = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [TICK_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic expired;
    logic older;
  } age_flags_t;

endpackage

### rtl/acm_entry_mem.sv
// Entry store: one write port, one registered read port.
module acm_entry_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  acm_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output acm_pkg::entry_t rdata
);
  import acm_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/acm_age_unit.sv
// Shared age unit: modular age of one entry, TTL check and oldest compare.
module acm_age_unit (
  input  logic [acm_pkg::TICK_W-1:0] now,
  input  logic [acm_pkg::TICK_W-1:0] stamp,
  input  logic [acm_pkg::TICK_W-1:0] ttl,
  input  logic [acm_pkg::TICK_W-1:0] best_age,
  output logic [acm_pkg::TICK_W-1:0] age,
  output acm_pkg::age_flags_t        flags
);
  import acm_pkg::*;

  // wraps modulo 2^48 by width
  assign age           = now - stamp;
  assign flags.expired = (ttl != '0) && (age > ttl);
  assign flags.older   = age > best_age;

endmodule

### rtl/arp_cache_engine_top.sv
// ARP cache engine top level: sequencer, valid bits, counters and ports.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tuser cmd; tdata ip, mac, now
//  out_    | out | out_tvalid/out_tready| tdata found..miss_total
//  cfg_    | in  | APB, pready tied 1   | entry TTL at byte address 0
//
// One request at a time; in_tready is high only in idle. A scan reads one entry
// per cycle, then drains the read port; updates then pass through a write state,
// and every command through a result state. Clear, no-op and rejected updates
// go straight from idle to the result state.
// A waiting result stalls only the next request's result state, until out_tready.
// Reset clears valid bits, counters and the TTL register.
module arp_cache_engine_top #(
  parameter int ENTRIES = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [127:80] now_ticks, [79:32] mac_addr, [31:0] ip_addr
  input  logic [acm_pkg::IN_DATA_W-1:0]   in_tdata,
  // [1:0] cmd
  input  logic [acm_pkg::CMD_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] found, [48:1] mac_out, [54:49] slot, [55] ignored,
  // [87:56] hit_total, [119:88] miss_total
  output logic [acm_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [acm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [acm_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [acm_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import acm_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  state_t               state_r, state_nxt;
  logic [ENTRIES-1:0]   valid_r;
  logic [TICK_W-1:0]    ttl_r;
  logic [TOTAL_W-1:0]   hit_cnt_r, miss_cnt_r, hit_cnt_nxt, miss_cnt_nxt;
  logic                 out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  // current request
  cmd_t                 cmd_r;
  logic [IP_W-1:0]      ip_r;
  logic [MAC_W-1:0]     mac_r;
  logic [TICK_W-1:0]    now_r;
  logic                 ign_r;

  // scan state
  logic [CNT_W-1:0]     rd_cnt_r;
  logic                 pv_r;
  logic [IDX_W-1:0]     pidx_r;
  logic                 match_r, free_r, old_v_r;
  logic [IDX_W-1:0]     match_idx_r, free_idx_r, old_idx_r, slot_r;
  logic [MAC_W-1:0]     match_mac_r;
  logic [TICK_W-1:0]    old_age_r;

  logic                 in_fire, bad_update, mem_re, mem_we, done_fire, cfg_wr;
  cmd_t                 in_cmd;
  logic [IP_W-1:0]      in_ip;
  logic [MAC_W-1:0]     in_mac;
  logic [TICK_W-1:0]    in_now;
  entry_t               rd_data, wr_data;
  logic [IDX_W-1:0]     wr_idx;
  logic [TICK_W-1:0]    age;
  age_flags_t           flags;
  logic                 ent_v, ent_exp, ent_live, ent_match;
  logic                 res_found;
  logic [SLOT_W-1:0]    res_slot;
  logic [MAC_W-1:0]     res_mac;

  assign in_cmd  = cmd_t'(in_tuser);
  assign in_ip   = in_tdata[31:0];
  assign in_mac  = in_tdata[79:32];
  assign in_now  = in_tdata[127:80];
  assign in_fire = in_tvalid && in_tready;
  assign bad_update = (in_ip == IP_ZERO) || (in_mac == MAC_ZERO) || (in_mac == MAC_BCAST);

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[3] == REG_TTL) ? CFG_DATA_W'(ttl_r) : '0;

  acm_entry_mem #(
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_idx),
    .wdata (wr_data),
    .re    (mem_re),
    .raddr (rd_cnt_r[IDX_W-1:0]),
    .rdata (rd_data)
  );

  acm_age_unit u_age (
    .now      (now_r),
    .stamp    (rd_data.stamp),
    .ttl      (ttl_r),
    .best_age (old_age_r),
    .age      (age),
    .flags    (flags)
  );

  // per-entry evaluation; expiry applies to lookups only
  assign ent_v     = valid_r[pidx_r];
  assign ent_exp   = (cmd_r == CMD_LOOKUP) && flags.expired;
  assign ent_live  = ent_v && !ent_exp;
  assign ent_match = ent_live && (rd_data.ip == ip_r);

  assign wr_idx  = match_r ? match_idx_r : (free_r ? free_idx_r : old_idx_r);
  assign wr_data = '{ip: ip_r, mac: mac_r, stamp: now_r};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    done_fire = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_fire) begin
          if (in_cmd == CMD_LOOKUP || (in_cmd == CMD_UPDATE && !bad_update)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        mem_re = rd_cnt_r < CNT_W'(ENTRIES);
        if (!mem_re && !pv_r) begin
          state_nxt = (cmd_r == CMD_UPDATE) ? ST_WRITE : ST_DONE;
        end
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          done_fire = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result assembly
  always_comb begin
    res_found    = (cmd_r == CMD_LOOKUP) && match_r;
    res_mac      = res_found ? match_mac_r : MAC_ZERO;
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (res_found) begin
      res_slot = SLOT_W'(match_idx_r);
    end else if (cmd_r == CMD_UPDATE && !ign_r) begin
      res_slot = SLOT_W'(slot_r);
    end else begin
      res_slot = '0;
    end
    if (cmd_r == CMD_LOOKUP) begin
      if (match_r) begin
        hit_cnt_nxt = hit_cnt_r + 1'b1;
      end else begin
        miss_cnt_nxt = miss_cnt_r + 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      ttl_r        <= '0;
      hit_cnt_r    <= '0;
      miss_cnt_r   <= '0;
      out_tvalid_r <= 1'b0;
      pv_r         <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && cfg_paddr[3] == REG_TTL) begin
        ttl_r <= cfg_pwdata[TICK_W-1:0];
      end
      if (in_fire) begin
        pv_r <= 1'b0;
        if (in_cmd == CMD_CLEAR) begin
          valid_r <= '0;
        end
      end else if (state_r == ST_SCAN) begin
        pv_r <= mem_re;
        if (pv_r && ent_v && ent_exp) begin
          valid_r[pidx_r] <= 1'b0;
        end
      end
      if (mem_we) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (done_fire) begin
        out_tvalid_r <= 1'b1;
        hit_cnt_r    <= hit_cnt_nxt;
        miss_cnt_r   <= miss_cnt_nxt;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // request and scan datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r    <= in_cmd;
      ip_r     <= in_ip;
      mac_r    <= in_mac;
      now_r    <= in_now;
      ign_r    <= (in_cmd == CMD_UPDATE) && bad_update;
      rd_cnt_r <= '0;
      match_r  <= 1'b0;
      free_r   <= 1'b0;
      old_v_r  <= 1'b0;
    end else if (state_r == ST_SCAN) begin
      if (mem_re) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
        pidx_r   <= rd_cnt_r[IDX_W-1:0];
      end
      // first match wins; later entries no longer feed free or oldest
      if (pv_r && !match_r) begin
        if (ent_match) begin
          match_r     <= 1'b1;
          match_idx_r <= pidx_r;
          match_mac_r <= rd_data.mac;
        end else begin
          if (!ent_v && !free_r) begin
            free_r     <= 1'b1;
            free_idx_r <= pidx_r;
          end
          if (ent_v && (!old_v_r || flags.older)) begin
            old_v_r   <= 1'b1;
            old_age_r <= age;
            old_idx_r <= pidx_r;
          end
        end
      end
    end
    if (mem_we) begin
      slot_r <= wr_idx;
    end
    if (done_fire) begin
      out_tdata_r <= {miss_cnt_nxt, hit_cnt_nxt, ign_r, res_slot, res_mac, res_found};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
